@@ rtl/core/ctc_pkg.sv @@
// Shared types and codes for the 16-bit capture timer/counter.
package ctc_pkg;

  localparam int CNT_W = 16;
  localparam int DATA_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_EVENT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  localparam logic [1:0] SEL_COUNT   = 2'd0;
  localparam logic [1:0] SEL_COMPARE = 2'd1;
  localparam logic [1:0] SEL_FLAGS   = 2'd2;
  localparam logic [1:0] SEL_STATUS  = 2'd3;

  localparam logic [2:0] MODE_PERIODIC = 3'd0;
  localparam logic [2:0] MODE_TIMEOUT  = 3'd1;
  localparam logic [2:0] MODE_CAPTURE  = 3'd2;
  localparam logic [2:0] MODE_FREQ     = 3'd3;
  localparam logic [2:0] MODE_PWIDTH   = 3'd4;
  localparam logic [2:0] MODE_FREQ_PW  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_FALL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN     = 3'd5;

  localparam int FLAG_CAPT_BIT = 0;
  localparam int FLAG_OVF_BIT  = 1;

  localparam logic [1:0] DUAL_IDLE    = 2'd0;
  localparam logic [1:0] DUAL_PERIOD  = 2'd1;
  localparam logic [1:0] DUAL_WIDTH   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic              evt_level;
    logic [1:0]        reg_select;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              capt_flag;
    logic              ovf_flag;
    logic              capt_event_pulse;
    logic              interrupt_request;
    logic              running;
  } res_t;

endpackage

@@ rtl/core/ctc_in_stage.sv @@
// Input register stage that holds one accepted word until the engine takes it.
module ctc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ctc_pkg::item_t in_item,
  input  logic          adv,
  output logic          s1_vld,
  output ctc_pkg::item_t s1_item
);

  logic           vld_r;
  ctc_pkg::item_t item_r;
  logic           load;

  assign load     = !vld_r || adv;
  assign in_stall = vld_r && !adv;
  assign s1_vld   = vld_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/ctc_engine.sv @@
// Timer state, configuration registers and the single-pass next-state logic.
module ctc_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  ctc_pkg::item_t                   item,
  input  logic                             cfg_we,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ctc_pkg::res_t                    res
);

  logic                      en_r, en_nxt;
  logic [2:0]                mode_r, mode_nxt;
  logic                      div2_r, div2_nxt;
  logic                      edge_fall_r, edge_fall_nxt;
  logic                      evt_en_r, evt_en_nxt;
  logic                      irq_en_r, irq_en_nxt;
  logic [ctc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ctc_pkg::CNT_W-1:0] top_r, top_nxt;
  logic                      phase_r, phase_nxt;
  logic                      run_r, run_nxt;
  logic                      capt_r, capt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      last_lvl_r, last_lvl_nxt;
  logic                      armed_r, armed_nxt;
  logic [1:0]                dual_r, dual_nxt;

  logic                        pulse;
  logic [ctc_pkg::DATA_W-1:0]  rd;
  logic                        adv;
  logic                        rise;
  logic                        fall;
  logic                        active;

  always_comb begin
    en_nxt        = en_r;
    mode_nxt      = mode_r;
    div2_nxt      = div2_r;
    edge_fall_nxt = edge_fall_r;
    evt_en_nxt    = evt_en_r;
    irq_en_nxt    = irq_en_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    phase_nxt     = phase_r;
    run_nxt       = run_r;
    capt_nxt      = capt_r;
    ovf_nxt       = ovf_r;
    last_lvl_nxt  = last_lvl_r;
    armed_nxt     = armed_r;
    dual_nxt      = dual_r;
    pulse         = 1'b0;
    rd            = '0;
    adv           = 1'b0;
    rise          = !last_lvl_r && item.evt_level;
    fall          = last_lvl_r && !item.evt_level;
    active        = edge_fall_r ? fall : rise;

    if (cfg_we) begin
      case (cfg_idx)
        ctc_pkg::CFG_ENABLE: begin
          en_nxt = cfg_data[0];
        end
        ctc_pkg::CFG_MODE: begin
          mode_nxt  = cfg_data[2:0];
          armed_nxt = 1'b0;
          dual_nxt  = ctc_pkg::DUAL_IDLE;
        end
        ctc_pkg::CFG_DIV2:      div2_nxt      = cfg_data[0];
        ctc_pkg::CFG_EDGE_FALL: edge_fall_nxt = cfg_data[0];
        ctc_pkg::CFG_EVENT_EN:  evt_en_nxt    = cfg_data[0];
        ctc_pkg::CFG_IRQ_EN:    irq_en_nxt    = cfg_data[0];
        default: ;
      endcase
      if (cfg_idx == ctc_pkg::CFG_ENABLE || cfg_idx == ctc_pkg::CFG_MODE ||
          cfg_idx == ctc_pkg::CFG_DIV2) begin
        run_nxt   = en_nxt && (mode_nxt inside {ctc_pkg::MODE_PERIODIC,
                                                ctc_pkg::MODE_CAPTURE,
                                                ctc_pkg::MODE_FREQ});
        phase_nxt = 1'b0;
      end
    end else if (fire) begin
      case (item.action)
        ctc_pkg::ACT_TICK: begin
          if (en_r && run_r) begin
            if (div2_r) begin
              phase_nxt = !phase_r;
              adv       = phase_r;
            end else begin
              phase_nxt = 1'b0;
              adv       = 1'b1;
            end
            if (adv) begin
              case (mode_r)
                ctc_pkg::MODE_PERIODIC: begin
                  if (count_r == top_r) begin
                    count_nxt = '0;
                    capt_nxt  = 1'b1;
                    pulse     = 1'b1;
                  end else begin
                    count_nxt = count_r + 1'b1;
                  end
                end
                ctc_pkg::MODE_TIMEOUT: begin
                  if (count_r == top_r) begin
                    run_nxt   = 1'b0;
                    phase_nxt = 1'b0;
                    capt_nxt  = 1'b1;
                    pulse     = 1'b1;
                  end else begin
                    count_nxt = count_r + 1'b1;
                  end
                end
                ctc_pkg::MODE_CAPTURE, ctc_pkg::MODE_FREQ,
                ctc_pkg::MODE_PWIDTH, ctc_pkg::MODE_FREQ_PW: begin
                  if (count_r == ctc_pkg::CNT_MAX) begin
                    ovf_nxt = 1'b1;
                  end
                  count_nxt = count_r + 1'b1;
                end
                default: begin
                  run_nxt   = 1'b0;
                  phase_nxt = 1'b0;
                end
              endcase
            end
          end
        end
        ctc_pkg::ACT_EVENT: begin
          last_lvl_nxt = item.evt_level;
          if (en_r && evt_en_r && (last_lvl_r != item.evt_level)) begin
            case (mode_r)
              ctc_pkg::MODE_TIMEOUT: begin
                if (active) begin
                  phase_nxt = 1'b0;
                  if (run_r) begin
                    run_nxt = 1'b0;
                  end else begin
                    run_nxt   = 1'b1;
                    count_nxt = '0;
                  end
                end
              end
              ctc_pkg::MODE_CAPTURE: begin
                if (active) begin
                  top_nxt  = count_r;
                  capt_nxt = 1'b1;
                  pulse    = 1'b1;
                end
              end
              ctc_pkg::MODE_FREQ: begin
                if (active) begin
                  top_nxt   = count_r;
                  capt_nxt  = 1'b1;
                  pulse     = 1'b1;
                  run_nxt   = 1'b1;
                  count_nxt = '0;
                  phase_nxt = 1'b0;
                end
              end
              ctc_pkg::MODE_PWIDTH: begin
                if (rise) begin
                  armed_nxt = 1'b1;
                  run_nxt   = 1'b1;
                  count_nxt = '0;
                  phase_nxt = 1'b0;
                end else if (fall && armed_r) begin
                  top_nxt   = count_r;
                  capt_nxt  = 1'b1;
                  pulse     = 1'b1;
                  run_nxt   = 1'b0;
                  phase_nxt = 1'b0;
                  armed_nxt = 1'b0;
                end
              end
              ctc_pkg::MODE_FREQ_PW: begin
                if (rise) begin
                  phase_nxt = 1'b0;
                  if (dual_r == ctc_pkg::DUAL_IDLE) begin
                    dual_nxt  = ctc_pkg::DUAL_PERIOD;
                    run_nxt   = 1'b1;
                    count_nxt = '0;
                  end else begin
                    run_nxt  = 1'b0;
                    capt_nxt = 1'b1;
                    pulse    = 1'b1;
                    dual_nxt = ctc_pkg::DUAL_IDLE;
                  end
                end else if (fall && dual_r == ctc_pkg::DUAL_PERIOD) begin
                  top_nxt  = count_r;
                  dual_nxt = ctc_pkg::DUAL_WIDTH;
                end
              end
              default: ;
            endcase
          end
        end
        ctc_pkg::ACT_READ: begin
          case (item.reg_select)
            ctc_pkg::SEL_COUNT: rd = count_r;
            ctc_pkg::SEL_COMPARE: begin
              rd = top_r;
              if (mode_r inside {ctc_pkg::MODE_CAPTURE, ctc_pkg::MODE_FREQ,
                                 ctc_pkg::MODE_PWIDTH, ctc_pkg::MODE_FREQ_PW}) begin
                capt_nxt = 1'b0;
              end
            end
            ctc_pkg::SEL_FLAGS: rd = {{(ctc_pkg::DATA_W-2){1'b0}}, ovf_r, capt_r};
            default:            rd = {{(ctc_pkg::DATA_W-1){1'b0}}, run_r};
          endcase
        end
        default: begin
          if (item.reg_select == ctc_pkg::SEL_COMPARE) begin
            top_nxt = item.write_data;
          end else if (item.reg_select == ctc_pkg::SEL_FLAGS) begin
            if (item.write_data[ctc_pkg::FLAG_CAPT_BIT]) begin
              capt_nxt = 1'b0;
            end
            if (item.write_data[ctc_pkg::FLAG_OVF_BIT]) begin
              ovf_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  assign res.read_data         = rd;
  assign res.capt_flag         = capt_nxt;
  assign res.ovf_flag          = ovf_nxt;
  assign res.capt_event_pulse  = pulse;
  assign res.interrupt_request = capt_nxt && irq_en_r;
  assign res.running           = run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      mode_r      <= ctc_pkg::MODE_PERIODIC;
      div2_r      <= 1'b0;
      edge_fall_r <= 1'b0;
      evt_en_r    <= 1'b0;
      irq_en_r    <= 1'b0;
      count_r     <= '0;
      top_r       <= '0;
      phase_r     <= 1'b0;
      run_r       <= 1'b0;
      capt_r      <= 1'b0;
      ovf_r       <= 1'b0;
      last_lvl_r  <= 1'b0;
      armed_r     <= 1'b0;
      dual_r      <= ctc_pkg::DUAL_IDLE;
    end else begin
      en_r        <= en_nxt;
      mode_r      <= mode_nxt;
      div2_r      <= div2_nxt;
      edge_fall_r <= edge_fall_nxt;
      evt_en_r    <= evt_en_nxt;
      irq_en_r    <= irq_en_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      phase_r     <= phase_nxt;
      run_r       <= run_nxt;
      capt_r      <= capt_nxt;
      ovf_r       <= ovf_nxt;
      last_lvl_r  <= last_lvl_nxt;
      armed_r     <= armed_nxt;
      dual_r      <= dual_nxt;
    end
  end

  a_run_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> en_r) else $error("counter running while disabled");

  a_run_defined_mode: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (mode_r <= ctc_pkg::MODE_FREQ_PW))
    else $error("counter running in an undefined mode");

  a_phase_needs_div2: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> div2_r) else $error("prescaler phase set without divide-by-two");

  a_armed_in_pwidth: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (mode_r == ctc_pkg::MODE_PWIDTH))
    else $error("width measurement armed outside pulse-width mode");

  a_dual_in_freq_pw: assert property (@(posedge clk) disable iff (!rst_n)
    (dual_r != ctc_pkg::DUAL_IDLE) |-> (mode_r == ctc_pkg::MODE_FREQ_PW))
    else $error("dual stage active outside frequency and pulse-width mode");

endmodule

@@ rtl/core/capture_timer_counter_16bit.sv @@
// Top level of the 16-bit timer/counter with periodic, time-out, capture, frequency and pulse-width modes.
// An accepted word is held in the input register, then its result is loaded into the result register;
// an output stall holds it in the input register. One word per cycle while the output is not stalled; the
// input register and the result register are each one stage, and the state update is done in one pass between them.
// Reset is synchronous and active low; it clears all timer state, the configuration
// and both stage valid bits.
module capture_timer_counter_16bit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic                             in_evt_level,
  input  logic [1:0]                       in_reg_select,
  input  logic [ctc_pkg::DATA_W-1:0]       in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ctc_pkg::DATA_W-1:0]       out_read_data,
  output logic                             out_capt_flag,
  output logic                             out_ovf_flag,
  output logic                             out_capt_event_pulse,
  output logic                             out_interrupt_request,
  output logic                             out_running,
  input  logic                             cfg_write_en,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]   cfg_write_data
);

  ctc_pkg::item_t in_item;
  ctc_pkg::item_t s1_item;
  ctc_pkg::res_t  res;
  ctc_pkg::res_t  res_r;
  logic           s1_vld;
  logic           adv;
  logic           fire;
  logic           out_vld_r;

  assign in_item.action      = in_action;
  assign in_item.evt_level   = in_evt_level;
  assign in_item.reg_select  = in_reg_select;
  assign in_item.write_data  = in_write_data;

  assign adv  = !out_vld_r || !out_stall;
  assign fire = s1_vld && adv;

  ctc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_vld   (s1_vld),
    .s1_item  (s1_item)
  );

  ctc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (s1_item),
    .cfg_we   (cfg_write_en),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_write_data),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_read_data         = res_r.read_data;
  assign out_capt_flag         = res_r.capt_flag;
  assign out_ovf_flag          = res_r.ovf_flag;
  assign out_capt_event_pulse  = res_r.capt_event_pulse;
  assign out_interrupt_request = res_r.interrupt_request;
  assign out_running           = res_r.running;

  a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.capt_event_pulse) |-> res_r.capt_flag)
    else $error("capture event without capture flag");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r) else $error("processed word did not reach the output");

  a_irq_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.interrupt_request) |-> res_r.capt_flag)
    else $error("interrupt request without capture flag");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the 16-bit capture timer/counter.
module testbench;
  import ctc_pkg::*;

  localparam int IDLE_MAX = 19;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_WORDS = 550;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_DATA_W-1:0] CFG_SET = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] CFG_CLR = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = ACT_TICK;
  logic                  in_evt_level = 1'b0;
  logic [1:0]            in_reg_select = SEL_COUNT;
  logic [DATA_W-1:0]     in_write_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_read_data;
  logic                  out_capt_flag;
  logic                  out_ovf_flag;
  logic                  out_capt_event_pulse;
  logic                  out_interrupt_request;
  logic                  out_running;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_write_data = '0;

  capture_timer_counter_16bit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer model state and configuration, all at their reset values.
  logic             en = 1'b0, div2 = 1'b0, efall = 1'b0, ev_en = 1'b0, irq_en = 1'b0;
  logic [2:0]       mode = MODE_PERIODIC;
  logic [CNT_W-1:0] tmr_count = '0, tmr_compare = '0;
  logic             phase = 1'b0, run = 1'b0, capt = 1'b0, ovf = 1'b0;
  logic             last_level = 1'b0, width_armed = 1'b0;
  logic [1:0]       dual_stage = DUAL_IDLE;

  res_t due_outputs[$];
  res_t want;
  int   errors = 0;
  int   cycles = 0;
  int   rx_hold = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  function automatic void restart(input logic go, input logic [CNT_W-1:0] value);
    run = go;
    tmr_count = value;
    phase = 1'b0;
  endfunction

  function automatic void rearm();
    restart(en && (mode == MODE_PERIODIC || mode == MODE_CAPTURE || mode == MODE_FREQ),
            tmr_count);
  endfunction

  function automatic res_t timer_result(input logic [1:0] act, input logic lvl,
                                        input logic [1:0] sel, input logic [DATA_W-1:0] data);
    res_t r;
    logic old, rise, fall, hit, pulse;
    r = '0;
    pulse = 1'b0;
    case (act)
      ACT_TICK: begin
        if (en && run) begin
          phase = div2 ? ~phase : 1'b0;
          if (!phase) begin
            case (mode)
              MODE_PERIODIC: begin
                if (tmr_count == tmr_compare) begin
                  tmr_count = '0;
                  capt = 1'b1;
                  pulse = 1'b1;
                end else tmr_count = tmr_count + 1'b1;
              end
              MODE_TIMEOUT: begin
                if (tmr_count == tmr_compare) begin
                  restart(1'b0, tmr_count);
                  capt = 1'b1;
                  pulse = 1'b1;
                end else tmr_count = tmr_count + 1'b1;
              end
              MODE_CAPTURE, MODE_FREQ, MODE_PWIDTH, MODE_FREQ_PW: begin
                if (tmr_count == CNT_MAX) ovf = 1'b1;
                tmr_count = tmr_count + 1'b1;
              end
              default: restart(1'b0, tmr_count);
            endcase
          end
        end
      end
      ACT_EVENT: begin
        old = last_level;
        rise = !old && lvl;
        fall = old && !lvl;
        hit = efall ? fall : rise;
        last_level = lvl;
        if (en && ev_en && old != lvl) begin
          case (mode)
            MODE_TIMEOUT: begin
              if (hit) restart(!run, run ? tmr_count : '0);
            end
            MODE_CAPTURE: begin
              if (hit) begin
                tmr_compare = tmr_count;
                capt = 1'b1;
                pulse = 1'b1;
              end
            end
            MODE_FREQ: begin
              if (hit) begin
                tmr_compare = tmr_count;
                capt = 1'b1;
                pulse = 1'b1;
                restart(1'b1, '0);
              end
            end
            MODE_PWIDTH: begin
              if (rise) begin
                width_armed = 1'b1;
                restart(1'b1, '0);
              end else if (fall && width_armed) begin
                tmr_compare = tmr_count;
                capt = 1'b1;
                pulse = 1'b1;
                restart(1'b0, tmr_count);
                width_armed = 1'b0;
              end
            end
            MODE_FREQ_PW: begin
              if (rise) begin
                if (dual_stage == DUAL_IDLE) begin
                  dual_stage = DUAL_PERIOD;
                  restart(1'b1, '0);
                end else begin
                  restart(1'b0, tmr_count);
                  capt = 1'b1;
                  pulse = 1'b1;
                  dual_stage = DUAL_IDLE;
                end
              end else if (fall && dual_stage == DUAL_PERIOD) begin
                tmr_compare = tmr_count;
                dual_stage = DUAL_WIDTH;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_READ: begin
        case (sel)
          SEL_COUNT: r.read_data = tmr_count;
          SEL_COMPARE: begin
            r.read_data = tmr_compare;
            if (mode >= MODE_CAPTURE && mode <= MODE_FREQ_PW) capt = 1'b0;
          end
          SEL_FLAGS: begin
            r.read_data[FLAG_CAPT_BIT] = capt;
            r.read_data[FLAG_OVF_BIT] = ovf;
          end
          default: r.read_data = DATA_W'(run);
        endcase
      end
      default: begin
        if (sel == SEL_COMPARE) tmr_compare = data;
        else if (sel == SEL_FLAGS) begin
          if (data[FLAG_CAPT_BIT]) capt = 1'b0;
          if (data[FLAG_OVF_BIT]) ovf = 1'b0;
        end
      end
    endcase
    r.capt_flag = capt;
    r.ovf_flag = ovf;
    r.capt_event_pulse = pulse;
    r.interrupt_request = capt && irq_en;
    r.running = run;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] expv,
                                      input logic [DATA_W-1:0] got);
    if (expv !== got) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, expv, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        $display("%0t result word with none outstanding: expected none, got read_data %0h",
                 $time, out_read_data);
        errors++;
      end else begin
        want = due_outputs.pop_front();
        check_field("read_data", want.read_data, out_read_data);
        check_field("capt_flag", DATA_W'(want.capt_flag), DATA_W'(out_capt_flag));
        check_field("ovf_flag", DATA_W'(want.ovf_flag), DATA_W'(out_ovf_flag));
        check_field("capt_event_pulse", DATA_W'(want.capt_event_pulse),
                    DATA_W'(out_capt_event_pulse));
        check_field("interrupt_request", DATA_W'(want.interrupt_request),
                    DATA_W'(out_interrupt_request));
        check_field("running", DATA_W'(want.running), DATA_W'(out_running));
      end
      rx_hold = rx_quiet ? 0 : int'($urandom_range(0, IDLE_MAX));
    end else if (rx_hold > 0) rx_hold--;
    out_stall <= (rx_hold > 0);
  end

  task automatic send_word(input logic [1:0] act, input logic lvl, input logic [1:0] sel,
                           input logic [DATA_W-1:0] data);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(0, IDLE_MAX));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_evt_level <= lvl;
    in_reg_select <= sel;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    due_outputs.push_back(timer_result(act, lvl, sel, data));
  endtask

  task automatic tick(input int n);
    repeat (n) send_word(ACT_TICK, 1'b0, SEL_COUNT, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_ENABLE: begin
        en = value[0];
        rearm();
      end
      CFG_MODE: begin
        mode = value;
        width_armed = 1'b0;
        dual_stage = DUAL_IDLE;
        rearm();
      end
      CFG_DIV2: begin
        div2 = value[0];
        rearm();
      end
      CFG_EDGE_FALL: efall = value[0];
      CFG_EVENT_EN: ev_en = value[0];
      CFG_IRQ_EN: irq_en = value[0];
      default: ;
    endcase
  endtask

  task automatic test_register_access();
    send_word(ACT_READ, 1'b0, SEL_STATUS, '0);
    send_word(ACT_WRITE, 1'b1, SEL_COUNT, 16'hFFFF);
    send_word(ACT_WRITE, 1'b0, SEL_STATUS, 16'hFFFF);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, 16'hFFFF);
    send_word(ACT_READ, 1'b0, SEL_COMPARE, '0);
    send_word(ACT_READ, 1'b1, SEL_COUNT, '0);
    tick(1);
    send_word(ACT_WRITE, 1'b0, SEL_FLAGS, 16'hFFFF);
    send_word(ACT_READ, 1'b0, SEL_FLAGS, '0);
  endtask

  task automatic test_periodic();
    set_register(CFG_IRQ_EN, CFG_SET);
    set_register(CFG_MODE, MODE_PERIODIC);
    set_register(CFG_ENABLE, CFG_SET);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, 16'd2);
    tick(5);
    send_word(ACT_READ, 1'b0, SEL_FLAGS, '0);
    send_word(ACT_WRITE, 1'b0, SEL_FLAGS, 16'd1);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, 16'd1);
    tick(2);
    set_register(CFG_DIV2, CFG_SET);
    tick(3);
    set_register(CFG_DIV2, CFG_CLR);
  endtask

  task automatic test_timeout();
    set_register(CFG_MODE, MODE_TIMEOUT);
    set_register(CFG_EVENT_EN, CFG_SET);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, 16'd3);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    tick(5);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    tick(1);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    set_register(CFG_EDGE_FALL, CFG_SET);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_READ, 1'b0, SEL_STATUS, '0);
  endtask

  task automatic test_capture_modes();
    set_register(CFG_MODE, MODE_CAPTURE);
    tick(2);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_READ, 1'b0, SEL_COMPARE, '0);
    set_register(CFG_MODE, MODE_FREQ);
    set_register(CFG_EDGE_FALL, CFG_CLR);
    tick(1);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    send_word(ACT_READ, 1'b0, SEL_COMPARE, '0);
    send_word(ACT_READ, 1'b0, SEL_COUNT, '0);
  endtask

  task automatic test_pulse_width();
    set_register(CFG_MODE, MODE_PWIDTH);
    set_register(CFG_EDGE_FALL, CFG_SET);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    tick(2);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_READ, 1'b0, SEL_COMPARE, '0);
    set_register(CFG_MODE, MODE_FREQ_PW);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    tick(1);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    tick(1);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    send_word(ACT_READ, 1'b0, SEL_COMPARE, '0);
    set_register(CFG_EVENT_EN, CFG_CLR);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    send_word(ACT_EVENT, 1'b1, SEL_COUNT, '0);
    set_register(CFG_EVENT_EN, CFG_SET);
  endtask

  task automatic test_undefined_modes();
    set_register(CFG_MODE, MODE_FREQ_PW + 3'd1);
    tick(1);
    send_word(ACT_EVENT, 1'b0, SEL_COUNT, '0);
    set_register(CFG_MODE, MODE_FREQ_PW + 3'd2);
    tick(1);
    send_word(ACT_READ, 1'b0, SEL_STATUS, '0);
  endtask

  // Climb past the compare value all the way to the top of the count, then let
  // capture mode take the wrap so the overflow flag sets.
  task automatic test_counter_wrap();
    set_register(CFG_MODE, MODE_PERIODIC);
    drain();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_word(ACT_WRITE, 1'b0, SEL_FLAGS, 16'hFFFF);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, 16'd5);
    if (tmr_count == '0) tick(1);
    send_word(ACT_WRITE, 1'b0, SEL_COMPARE, '0);
    while (tmr_count != CNT_MAX) tick(1);
    set_register(CFG_MODE, MODE_CAPTURE);
    tick(2);
    send_word(ACT_READ, 1'b0, SEL_FLAGS, '0);
    send_word(ACT_WRITE, 1'b0, SEL_FLAGS, 16'd2);
    drain();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent, phase_len, pick, nregs;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] value;
    logic [1:0] sel;
    logic [DATA_W-1:0] data;
    logic lvl;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      nregs = (sent == 0) ? 6 : int'($urandom_range(1, 3));
      repeat (nregs) begin
        idx = (sent == 0) ? CFG_IDX_W'(6 - nregs) :
                            CFG_IDX_W'($urandom_range(CFG_ENABLE, CFG_IRQ_EN));
        case (idx)
          CFG_ENABLE: value = CFG_DATA_W'($urandom_range(0, 4) != 0);
          CFG_MODE: value = ($urandom_range(0, 19) == 0) ?
                            MODE_FREQ_PW + 3'($urandom_range(1, 2)) :
                            3'($urandom_range(MODE_PERIODIC, MODE_FREQ_PW));
          CFG_EVENT_EN: value = CFG_DATA_W'($urandom_range(0, 5) != 0);
          default: value = CFG_DATA_W'($urandom_range(0, 1));
        endcase
        set_register(idx, value);
        nregs--;
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      phase_len = int'($urandom_range(20, 60));
      repeat (phase_len) begin
        pick = int'($urandom_range(0, 99));
        sel = 2'($urandom_range(0, 3));
        data = DATA_W'($urandom_range(0, 16'hFFFF));
        lvl = ($urandom_range(0, 4) == 0) ? last_level : ~last_level;
        if (pick < 50) send_word(ACT_TICK, 1'($urandom_range(0, 1)), sel, data);
        else if (pick < 78) send_word(ACT_EVENT, lvl, sel, data);
        else if (pick < 90) send_word(ACT_READ, 1'($urandom_range(0, 1)), sel, data);
        else begin
          if (sel == SEL_COMPARE && $urandom_range(0, 3) != 0)
            data = DATA_W'($urandom_range(0, 12));
          send_word(ACT_WRITE, 1'($urandom_range(0, 1)), sel, data);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_periodic();
    test_timeout();
    test_capture_modes();
    test_pulse_width();
    test_undefined_modes();
    test_counter_wrap();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ctc_pkg.sv
rtl/core/ctc_in_stage.sv
rtl/core/ctc_engine.sv
rtl/core/capture_timer_counter_16bit.sv
dv/testbench.sv
